>>> rtl/length_prefixed_nal_to_annexb_defines.svh
// Assertion macros used by the converter's emit module.
`ifndef LENGTH_PREFIXED_NAL_TO_ANNEXB_DEFINES_SVH
`define LENGTH_PREFIXED_NAL_TO_ANNEXB_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define LPNA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpna: same-cycle property failed");

// Consequent in the cycle after the antecedent.
`define LPNA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpna: next-cycle property failed");

`endif

>>> rtl/lpna_pkg.sv
`timescale 1ns / 1ps
package lpna_pkg;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [2:0] LfbReset = 3'd4;
  localparam logic [2:0] LfbMin   = 3'd1;
  localparam logic [2:0] LfbMax   = 3'd4;

  localparam logic [1:0] StatusData   = 2'd0;
  localparam logic [1:0] StatusTrunc  = 2'd1;
  localparam logic [1:0] StatusTooBig = 2'd2;

  localparam logic [2:0] ScLenLong  = 3'd4;
  localparam logic [2:0] ScLenShort = 3'd3;

  localparam logic [5:0] NalTypeMask = 6'h3f;
  localparam logic [5:0] NalTypeVps  = 6'd32;
  localparam logic [5:0] NalTypePps  = 6'd34;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic [23:0] bytes_after;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_start_code;
    logic [1:0] status;
    logic       last_of_run;
  } out_req_t;

  // Everything one input byte causes: an optional start code followed by an
  // optional data or status result.
  typedef struct packed {
    logic [2:0] sc_len;
    logic       has_item;
    logic [7:0] item_byte;
    logic [1:0] item_status;
  } run_desc_t;

endpackage

>>> rtl/lpna_cfg.sv
`timescale 1ns / 1ps
module lpna_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpna_pkg::AddrW-1:0]    paddr,
  input  logic [lpna_pkg::DataW-1:0]    pwdata,
  output logic [lpna_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output logic [2:0]                    lfb_o
);

  logic [2:0] lfb_q, lfb_d;
  logic       sel_lfb;

  // Word index 0 holds the prefix length; other words read as zero.
  assign sel_lfb = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  always_comb begin
    lfb_d = lfb_q;
    if (psel && penable && pwrite && sel_lfb) begin
      lfb_d = pwdata[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfb_q <= lpna_pkg::LfbReset;
    end else begin
      lfb_q <= lfb_d;
    end
  end

  assign prdata = sel_lfb ? {{(lpna_pkg::DataW-3){1'b0}}, lfb_q} : '0;
  assign lfb_o  = lfb_q;

endmodule

>>> rtl/lpna_parse.sv
`timescale 1ns / 1ps
module lpna_parse #(
  parameter int unsigned PACKET_COUNT_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lpna_pkg::in_req_t   in_req_i,
  input  logic [2:0]          lfb_i,
  output lpna_pkg::run_desc_t desc_o
);

  localparam logic [1:0] PhLength = 2'd0;
  localparam logic [1:0] PhHead   = 2'd1;
  localparam logic [1:0] PhBody   = 2'd2;
  localparam logic [1:0] PhDrop   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  lbs_q, lbs_d;
  logic [31:0] nal_q, nal_d;
  logic        first_q, first_d;

  logic [23:0] after;
  logic        last;
  logic [2:0]  need;
  logic [2:0]  lbs_inc;
  logic [31:0] nal_shift;
  logic [5:0]  nal_type;
  logic        param_set;

  // The byte count wraps at the configured counter width.
  always_comb begin
    for (int i = 0; i < 24; i++) begin
      after[i] = in_req_i.bytes_after[i] & (i < PACKET_COUNT_BITS);
    end
  end

  assign last      = (after == 24'd0);
  assign lbs_inc   = lbs_q + 3'd1;
  assign nal_shift = {nal_q[23:0], in_req_i.in_byte};
  assign nal_type  = in_req_i.in_byte[6:1] & lpna_pkg::NalTypeMask;
  assign param_set = (nal_type >= lpna_pkg::NalTypeVps) && (nal_type <= lpna_pkg::NalTypePps);

  always_comb begin
    if (lfb_i < lpna_pkg::LfbMin) begin
      need = lpna_pkg::LfbMin;
    end else if (lfb_i > lpna_pkg::LfbMax) begin
      need = lpna_pkg::LfbMax;
    end else begin
      need = lfb_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    lbs_d   = lbs_q;
    nal_d   = nal_q;
    first_d = first_q;
    desc_o  = '0;
    unique case (phase_q)
      PhLength: begin
        nal_d = nal_shift;
        lbs_d = lbs_inc;
        if (lbs_inc < need) begin
          if (last) begin
            desc_o.has_item    = 1'b1;
            desc_o.item_status = lpna_pkg::StatusTrunc;
          end
        end else begin
          lbs_d = 3'd0;
          if (nal_shift > {8'd0, after}) begin
            desc_o.has_item    = 1'b1;
            desc_o.item_status = lpna_pkg::StatusTooBig;
            nal_d   = 32'd0;
            phase_d = last ? PhLength : PhDrop;
          end else if (nal_shift == 32'd0) begin
            // An empty NAL still gets its start code.
            desc_o.sc_len = first_q ? lpna_pkg::ScLenLong : lpna_pkg::ScLenShort;
            first_d = 1'b0;
          end else begin
            phase_d = PhHead;
          end
        end
      end
      PhHead, PhBody: begin
        if (phase_q == PhHead) begin
          desc_o.sc_len = (first_q || param_set) ? lpna_pkg::ScLenLong
                                                 : lpna_pkg::ScLenShort;
          first_d = 1'b0;
        end
        desc_o.has_item    = 1'b1;
        desc_o.item_byte   = in_req_i.in_byte;
        desc_o.item_status = lpna_pkg::StatusData;
        nal_d   = nal_q - 32'd1;
        phase_d = (nal_d == 32'd0) ? PhLength : PhBody;
      end
      PhDrop: begin
      end
      default: begin
      end
    endcase
    // The last byte of a packet always restarts framing.
    if (last) begin
      phase_d = PhLength;
      lbs_d   = 3'd0;
      nal_d   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLength;
      lbs_q   <= 3'd0;
      nal_q   <= 32'd0;
      first_q <= 1'b1;
    end else if (accept_i) begin
      phase_q <= phase_d;
      lbs_q   <= lbs_d;
      nal_q   <= nal_d;
      first_q <= first_d;
    end
  end

endmodule

>>> rtl/lpna_emit.sv
`timescale 1ns / 1ps
`include "length_prefixed_nal_to_annexb_defines.svh"
module lpna_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lpna_pkg::run_desc_t desc_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lpna_pkg::out_req_t  out_req_o
);

  lpna_pkg::run_desc_t desc_q;
  logic                busy_q, busy_d;
  logic [2:0]          pos_q, pos_d;
  logic [2:0]          total;
  logic [2:0]          total_in;
  logic                at_last;
  logic                in_sc;
  logic                pop;

  assign total    = desc_q.sc_len + {2'b00, desc_q.has_item};
  assign total_in = desc_i.sc_len + {2'b00, desc_i.has_item};
  assign at_last  = (pos_q == total - 3'd1);
  assign pop      = busy_q && out_ready_i;

  // A new run may enter while the final result of the current one leaves.
  assign can_load_o = !busy_q || (out_ready_i && at_last);

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (load_i) begin
      busy_d = 1'b1;
      pos_d  = 3'd0;
    end else if (pop) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      desc_q <= desc_i;
    end
  end

  assign in_sc = (pos_q < desc_q.sc_len);

  always_comb begin
    out_req_o.is_start_code = in_sc;
    out_req_o.last_of_run   = at_last;
    if (in_sc) begin
      out_req_o.out_byte = (pos_q == desc_q.sc_len - 3'd1) ? 8'h01 : 8'h00;
      out_req_o.status   = lpna_pkg::StatusData;
    end else begin
      out_req_o.out_byte = desc_q.item_byte;
      out_req_o.status   = desc_q.item_status;
    end
  end

  assign out_valid_o = busy_q;

  `LPNA_ASSERT_IMPL(a_no_load_on_stall, clk_i, rst_ni, busy_q && !out_ready_i, !load_i)
  `LPNA_ASSERT_IMPL(a_pos_in_run, clk_i, rst_ni, busy_q, pos_q < total)
  `LPNA_ASSERT_NEXT(a_load_starts_run, clk_i, rst_ni, load_i, busy_q && pos_q == 3'd0)
  `LPNA_ASSERT_IMPL(a_load_not_empty, clk_i, rst_ni, load_i, total_in != 3'd0)

endmodule

>>> rtl/length_prefixed_nal_to_annexb.sv
`timescale 1ns / 1ps
// Length-prefixed NAL to Annex B converter.
// Input channel (in_valid_i / in_ready_o / in_req_i) carries one packet byte per
// request, tagged with the number of packet bytes after it. Output channel
// (out_valid_o / out_ready_i / out_req_o) carries start-code bytes, NAL bytes
// and framing status results, with last_of_run set on the final result that
// one input byte causes. Prefix bytes normally cause no result.
// The APB port holds one register, the prefix length in bytes, at address 0.
// The results of a byte appear in the cycle after it is accepted. A
// byte that causes k results holds the output until all k have left, so
// body bytes and prefix bytes pass at one per cycle while the receiver does
// not stall, and a NAL header byte causes 4 or 5 results with its start code.
// When the receiver stalls, the output holds and the input stops taking
// bytes once the pending run cannot retire in that cycle.
// Reset clears framing, marks the next NAL as the first one (long start code)
// and sets the prefix length to 4.
module length_prefixed_nal_to_annexb #(
  parameter int unsigned PACKET_COUNT_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lpna_pkg::in_req_t          in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lpna_pkg::out_req_t         out_req_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpna_pkg::AddrW-1:0] paddr,
  input  logic [lpna_pkg::DataW-1:0] pwdata,
  output logic [lpna_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  logic                lfb;
  logic [2:0]          lfb_val;
  logic                accept;
  logic                load;
  lpna_pkg::run_desc_t desc;

  assign lfb = 1'b0;

  lpna_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lfb_o   (lfb_val)
  );

  assign accept = in_valid_i && in_ready_o;

  lpna_parse #(
    .PACKET_COUNT_BITS (PACKET_COUNT_BITS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_req_i (in_req_i),
    .lfb_i    (lfb_val | {2'b00, lfb}),
    .desc_o   (desc)
  );

  // Bytes that cause no result update the framing state only.
  assign load = accept && (desc.has_item || (desc.sc_len != 3'd0));

  lpna_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .desc_i      (desc),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
